>>> hdl/hhg_pkg.sv
// Shared types and constants of the HSV hue gradient generator.
// Used by the controller, the datapath, the divider and the top level.
package hhg_pkg;

	localparam int MAX_INNER_DEF = 62;
	localparam int COUNT_W = 6;
	localparam int CHAN_W = 8;
	localparam int DIV_NUM_W = 26;
	localparam int DIV_DEN_W = 10;
	localparam int ACC_W = 28;
	localparam int Q_FRAC = 16;
	localparam logic signed [ACC_W-1:0] HUE_FULL_Q = 28'sd23592960;
	localparam logic [ACC_W-1:0] ROUND_HALF = 28'd32768;
	localparam logic [28:0] CH_RECIP = 29'(((64'd1 << 48) + 64'd599999) / 64'd600000);
	localparam logic [16:0] V_RECIP = 17'(((64'd1 << 25) + 64'd509) / 64'd510);

	typedef enum logic [3:0] {
		OP_H1, OP_S1, OP_H2, OP_S2, OP_DH, OP_DS, OP_DV
	} op_t;

	typedef enum logic [1:0] {
		SEL_START, SEL_INNER, SEL_END
	} out_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     div_start;
		op_t      op;
		logic     prep;
		logic     init;
		logic     step;
		logic     conv1;
		logic     conv2;
		logic     conv3;
		logic     out_load;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
		logic n_zero;
		logic last_inner;
	} sts_t;

endpackage

>>> hdl/hhg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on hhg_pkg for the operand widths.
module hhg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [hhg_pkg::DIV_NUM_W-1:0] num,
	input  logic [hhg_pkg::DIV_DEN_W-1:0] den,
	output logic                          done,
	output logic [hhg_pkg::DIV_NUM_W-1:0] quo
);

	localparam int NW = hhg_pkg::DIV_NUM_W;
	localparam int DW = hhg_pkg::DIV_DEN_W;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic          ge;

	assign shifted = {rem_q, num_q[NW-1]};
	assign ge = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= CW'(NW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DW'(shifted - {1'b0, den_q}) : DW'(shifted);
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo = num_q;

endmodule

>>> hdl/hhg_datapath.sv
// Datapath: request registers, HSV conversion operands, step accumulators,
// HSV to RGB pipeline and the output register. Uses hhg_pkg and hhg_div.
module hhg_datapath #(
	parameter int MAX_INNER = hhg_pkg::MAX_INNER_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hhg_pkg::cmd_t               cmd,
	output hhg_pkg::sts_t               sts,
	input  logic [7:0]                  start_red,
	input  logic [7:0]                  start_green,
	input  logic [7:0]                  start_blue,
	input  logic [7:0]                  end_red,
	input  logic [7:0]                  end_green,
	input  logic [7:0]                  end_blue,
	input  logic [hhg_pkg::COUNT_W-1:0] inner_count,
	input  logic                        long_way,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_red,
	output logic [7:0]                  out_green,
	output logic [7:0]                  out_blue,
	output logic [hhg_pkg::COUNT_W-1:0] position,
	output logic                        final_colour
);

	localparam int CW = hhg_pkg::COUNT_W;
	localparam int AW = hhg_pkg::ACC_W;
	localparam int NW = hhg_pkg::DIV_NUM_W;
	localparam int DW = hhg_pkg::DIV_DEN_W;

	typedef struct packed {
		logic [7:0]  mx;
		logic [7:0]  d;
		logic [17:0] hnum;
	} ep_t;

	function automatic ep_t ep_calc(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		ep_t e;
		logic [7:0] mn;
		logic [11:0] w;
		logic [16:0] t;
		e.mx = r;
		mn = r;
		if (g > e.mx) e.mx = g;
		if (b > e.mx) e.mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		e.d = e.mx - mn;
		if (e.mx == r) begin
			w = 12'(g) - 12'(b);
			if (g < b) w = w + 12'(e.d) * 12'd6;
		end else if (e.mx == g) begin
			w = 12'(b) - 12'(r) + 12'(e.d) * 12'd2;
		end else begin
			w = 12'(r) - 12'(g) + 12'(e.d) * 12'd4;
		end
		t = 17'(w) * 17'd60;
		e.hnum = {t, 1'b0} + 18'(e.d);
		return e;
	endfunction

	// Value is (200 * max + 255) / 510, taken by reciprocal multiplication.
	function automatic logic [6:0] v_of(input logic [7:0] mx);
		logic [32:0] p;
		p = 33'(16'(mx) * 16'd200 + 16'd255) * 33'(hhg_pkg::V_RECIP);
		return p[31:25];
	endfunction

	logic [7:0] r1_q, g1_q, b1_q, r2_q, g2_q, b2_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] pos_q;
	logic lw_q;
	hhg_pkg::op_t cur_op_q;

	logic [8:0] h1_q, h2_q, hstart_q, mag_h_q;
	logic [6:0] s1_q, s2_q, v1_q, v2_q, mag_s_q, mag_v_q;
	logic neg_h_q, neg_s_q, neg_v_q;
	logic signed [AW-1:0] dh_q, ds_q, dv_q;
	logic signed [AW-1:0] ha_q, sa_q, va_q;

	logic [8:0] h_c1;
	logic [6:0] s_c1, v_c1;
	logic [12:0] xr_c2, xg_c2, xb_c2;
	logic [6:0] v_c2;
	logic [27:0] nr_c3, ng_c3, nb_c3;

	logic out_valid_q, final_q;
	logic [7:0] ored_q, ogreen_q, oblue_q;
	logic [CW-1:0] opos_q;

	ep_t ep1, ep2, ep_op, ep_res;
	logic [NW-1:0] div_num, div_quo;
	logic [DW-1:0] div_den;
	logic div_done;
	logic [6:0] np1;

	assign ep1 = ep_calc(r1_q, g1_q, b1_q);
	assign ep2 = ep_calc(r2_q, g2_q, b2_q);
	assign np1 = 7'(n_q) + 7'd1;

	always_comb begin
		ep_op = (cmd.op inside {hhg_pkg::OP_H2, hhg_pkg::OP_S2}) ? ep2 : ep1;
		ep_res = (cur_op_q inside {hhg_pkg::OP_H2, hhg_pkg::OP_S2}) ? ep2 : ep1;
	end

	always_comb begin
		case (cmd.op)
			hhg_pkg::OP_H1, hhg_pkg::OP_H2: begin
				div_num = NW'(ep_op.hnum);
				div_den = DW'({ep_op.d, 1'b0});
			end
			hhg_pkg::OP_S1, hhg_pkg::OP_S2: begin
				div_num = NW'(16'(ep_op.d) * 16'd200 + 16'(ep_op.mx));
				div_den = DW'({ep_op.mx, 1'b0});
			end
			hhg_pkg::OP_DH: begin
				div_num = {mag_h_q, 17'b0} + NW'(np1);
				div_den = DW'({np1, 1'b0});
			end
			hhg_pkg::OP_DS: begin
				div_num = NW'({mag_s_q, 17'b0}) + NW'(np1);
				div_den = DW'({np1, 1'b0});
			end
			hhg_pkg::OP_DV: begin
				div_num = NW'({mag_v_q, 17'b0}) + NW'(np1);
				div_den = DW'({np1, 1'b0});
			end
			default: begin
				div_num = '0;
				div_den = DW'(1);
			end
		endcase
	end

	hhg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	logic [8:0] hue_res;
	logic [6:0] sat_res;
	logic signed [AW-1:0] q_pos;

	always_comb begin
		if (ep_res.d == 8'd0) hue_res = '0;
		else if (div_quo >= NW'(360)) hue_res = 9'(div_quo - NW'(360));
		else hue_res = 9'(div_quo);
		sat_res = (ep_res.mx == 8'd0) ? 7'd0 : 7'(div_quo);
		q_pos = AW'(div_quo);
	end

	logic [8:0] h1e, h2e;
	logic signed [9:0] delta, delta_adj;
	logic [9:0] ad;
	logic signed [7:0] sdiff, vdiff;

	always_comb begin
		h1e = (ep1.d == 8'd0) ? h2_q : h1_q;
		h2e = (ep2.d == 8'd0) ? h1e : h2_q;
		delta = $signed({1'b0, h2e}) - $signed({1'b0, h1e});
		ad = delta[9] ? 10'(-delta) : 10'(delta);
		delta_adj = delta;
		if ((lw_q && ad < 10'd180) || (!lw_q && ad >= 10'd180))
			delta_adj = (delta > 10'sd0) ? delta - 10'sd360 : delta + 10'sd360;
		sdiff = $signed({1'b0, s2_q}) - $signed({1'b0, s1_q});
		vdiff = $signed({1'b0, v2_q}) - $signed({1'b0, v1_q});
	end

	logic signed [AW-1:0] ha_sum;
	logic [AW-1:0] hround, sround, vround;
	logic [11:0] hr, sr, vr;

	always_comb begin
		ha_sum = ha_q + dh_q;
		hround = AW'(ha_q) + hhg_pkg::ROUND_HALF;
		sround = AW'(sa_q) + hhg_pkg::ROUND_HALF;
		vround = AW'(va_q) + hhg_pkg::ROUND_HALF;
		hr = hround[AW-1:hhg_pkg::Q_FRAC];
		sr = sround[AW-1:hhg_pkg::Q_FRAC];
		vr = vround[AW-1:hhg_pkg::Q_FRAC];
	end

	logic [2:0] sector;
	logic [8:0] sbase;
	logic [5:0] m;
	logic [12:0] ms, low, fall, rise, full;

	always_comb begin
		if (h_c1 >= 9'd300) begin sector = 3'd5; sbase = 9'd300; end
		else if (h_c1 >= 9'd240) begin sector = 3'd4; sbase = 9'd240; end
		else if (h_c1 >= 9'd180) begin sector = 3'd3; sbase = 9'd180; end
		else if (h_c1 >= 9'd120) begin sector = 3'd2; sbase = 9'd120; end
		else if (h_c1 >= 9'd60) begin sector = 3'd1; sbase = 9'd60; end
		else begin sector = 3'd0; sbase = 9'd0; end
		m = 6'(h_c1 - sbase);
		ms = 13'(m) * 13'(s_c1);
		full = 13'd6000;
		low = 13'd60 * 13'(7'd100 - s_c1);
		fall = full - ms;
		rise = full - 13'(6'd60 - m) * 13'(s_c1);
	end

	logic [19:0] pr, pg, pb;
	logic [56:0] qr, qg, qb;

	always_comb begin
		pr = 20'(v_c2) * 20'(xr_c2);
		pg = 20'(v_c2) * 20'(xg_c2);
		pb = 20'(v_c2) * 20'(xb_c2);
		qr = 57'(nr_c3) * 57'(hhg_pkg::CH_RECIP);
		qg = 57'(ng_c3) * 57'(hhg_pkg::CH_RECIP);
		qb = 57'(nb_c3) * 57'(hhg_pkg::CH_RECIP);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			r1_q <= start_red;
			g1_q <= start_green;
			b1_q <= start_blue;
			r2_q <= end_red;
			g2_q <= end_green;
			b2_q <= end_blue;
			n_q <= (inner_count > CW'(MAX_INNER)) ? CW'(MAX_INNER) : inner_count;
			lw_q <= long_way;
		end
		if (cmd.div_start) cur_op_q <= cmd.op;
		if (cmd.div_start && cmd.op == hhg_pkg::OP_H1) begin
			v1_q <= v_of(ep1.mx);
			v2_q <= v_of(ep2.mx);
		end
		if (div_done) begin
			case (cur_op_q)
				hhg_pkg::OP_H1: h1_q <= hue_res;
				hhg_pkg::OP_S1: s1_q <= sat_res;
				hhg_pkg::OP_H2: h2_q <= hue_res;
				hhg_pkg::OP_S2: s2_q <= sat_res;
				hhg_pkg::OP_DH: dh_q <= neg_h_q ? -q_pos : q_pos;
				hhg_pkg::OP_DS: ds_q <= neg_s_q ? -q_pos : q_pos;
				hhg_pkg::OP_DV: dv_q <= neg_v_q ? -q_pos : q_pos;
				default: ;
			endcase
		end
		if (cmd.prep) begin
			hstart_q <= h1e;
			neg_h_q <= delta_adj[9];
			mag_h_q <= delta_adj[9] ? 9'(-delta_adj) : 9'(delta_adj);
			neg_s_q <= sdiff[7];
			mag_s_q <= sdiff[7] ? 7'(-sdiff) : 7'(sdiff);
			neg_v_q <= vdiff[7];
			mag_v_q <= vdiff[7] ? 7'(-vdiff) : 7'(vdiff);
		end
		if (cmd.init) begin
			ha_q <= $signed({3'b0, hstart_q, 16'b0});
			sa_q <= $signed({5'b0, s1_q, 16'b0});
			va_q <= $signed({5'b0, v1_q, 16'b0});
		end else if (cmd.step) begin
			if (ha_sum < 0) ha_q <= ha_sum + hhg_pkg::HUE_FULL_Q;
			else if (ha_sum >= hhg_pkg::HUE_FULL_Q) ha_q <= ha_sum - hhg_pkg::HUE_FULL_Q;
			else ha_q <= ha_sum;
			sa_q <= sa_q + ds_q;
			va_q <= va_q + dv_q;
		end
		if (cmd.conv1) begin
			h_c1 <= (hr == 12'd360) ? 9'd0 : 9'(hr);
			s_c1 <= sa_q[AW-1] ? 7'd0 : ((sr > 12'd100) ? 7'd100 : 7'(sr));
			v_c1 <= va_q[AW-1] ? 7'd0 : ((vr > 12'd100) ? 7'd100 : 7'(vr));
		end
		if (cmd.conv2) begin
			v_c2 <= v_c1;
			case (sector)
				3'd0: begin xr_c2 <= full; xg_c2 <= rise; xb_c2 <= low; end
				3'd1: begin xr_c2 <= fall; xg_c2 <= full; xb_c2 <= low; end
				3'd2: begin xr_c2 <= low; xg_c2 <= full; xb_c2 <= rise; end
				3'd3: begin xr_c2 <= low; xg_c2 <= fall; xb_c2 <= full; end
				3'd4: begin xr_c2 <= rise; xg_c2 <= low; xb_c2 <= full; end
				default: begin xr_c2 <= full; xg_c2 <= low; xb_c2 <= fall; end
			endcase
		end
		if (cmd.conv3) begin
			nr_c3 <= {pr, 8'b0} - 28'(pr);
			ng_c3 <= {pg, 8'b0} - 28'(pg);
			nb_c3 <= {pb, 8'b0} - 28'(pb);
		end
		if (cmd.out_load) begin
			case (cmd.out_sel)
				hhg_pkg::SEL_START: begin
					ored_q <= r1_q;
					ogreen_q <= g1_q;
					oblue_q <= b1_q;
					opos_q <= '0;
				end
				hhg_pkg::SEL_INNER: begin
					ored_q <= qr[55:48];
					ogreen_q <= qg[55:48];
					oblue_q <= qb[55:48];
					opos_q <= pos_q;
				end
				default: begin
					ored_q <= r2_q;
					ogreen_q <= g2_q;
					oblue_q <= b2_q;
					opos_q <= pos_q + CW'(1);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			final_q <= 1'b0;
			pos_q <= '0;
		end else begin
			if (cmd.load_in) pos_q <= '0;
			else if (cmd.step) pos_q <= pos_q + CW'(1);
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				final_q <= (cmd.out_sel == hhg_pkg::SEL_END);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.n_zero = (n_q == '0);
	assign sts.last_inner = (pos_q == n_q);

	assign out_valid = out_valid_q;
	assign out_red = ored_q;
	assign out_green = ogreen_q;
	assign out_blue = oblue_q;
	assign position = opos_q;
	assign final_colour = final_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free) else $error("output register overwritten");
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.conv2 |-> (h_c1 < 9'd360)) else $error("hue out of range");
	a_sv_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.conv2 |-> (s_c1 <= 7'd100 && v_c1 <= 7'd100)) else $error("s or v out of range");

endmodule

>>> hdl/hhg_ctrl.sv
// Controller state machine that sequences divisions, steps and emission.
// Depends on hhg_pkg for the command and status types.
module hhg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  hhg_pkg::sts_t sts,
	output hhg_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_DIV, S_WAIT, S_PREP, S_INIT, S_STEP,
		S_CONV1, S_CONV2, S_CONV3, S_EMIT, S_END
	} state_t;

	state_t state_q, state_d;
	hhg_pkg::op_t op_q, op_d;

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		state_d = state_q;
		op_d = op_q;
		case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) state_d = S_START;
			end
			S_START: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel = hhg_pkg::SEL_START;
					op_d = hhg_pkg::OP_H1;
					state_d = sts.n_zero ? S_END : S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_start = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (sts.div_done) begin
					if (op_q == hhg_pkg::OP_S2) state_d = S_PREP;
					else if (op_q == hhg_pkg::OP_DV) state_d = S_INIT;
					else begin
						op_d = hhg_pkg::op_t'(op_q + 4'd1);
						state_d = S_DIV;
					end
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				op_d = hhg_pkg::OP_DH;
				state_d = S_DIV;
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d = S_STEP;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d = S_CONV1;
			end
			S_CONV1: begin
				cmd.conv1 = 1'b1;
				state_d = S_CONV2;
			end
			S_CONV2: begin
				cmd.conv2 = 1'b1;
				state_d = S_CONV3;
			end
			S_CONV3: begin
				cmd.conv3 = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel = hhg_pkg::SEL_INNER;
					state_d = sts.last_inner ? S_END : S_STEP;
				end
			end
			S_END: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel = hhg_pkg::SEL_END;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= hhg_pkg::OP_H1;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

>>> hdl/hsv_hue_gradient_generator_unit.sv
// Top level of the HSV hue gradient generator.
// Depends on hhg_pkg, hhg_ctrl and hhg_datapath.
//
// One request carries a start and an end color, an inner step count n and
// a long-way flag. n is capped at MAX_INNER, and the block answers with n+2
// colors on the output, position 0 first, final_colour set on the end color.
// The input channel takes a request only while the block is idle; in_stall
// is high from acceptance until the end color sits in the output register.
// The start color is loaded once the output register is free. For n above
// zero, seven divisions follow on one shared bit-serial divider before the
// first inner color. Each inner color then passes through the step state and
// the CONV1, CONV2 and CONV3 states of the HSV to RGB sequence.
// A stalled output holds its color, and the sequencer waits until the
// output register is free. After reset no request is in flight and
// out_valid is low.
module hsv_hue_gradient_generator_unit #(
	parameter int MAX_INNER = hhg_pkg::MAX_INNER_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  start_red,
	input  logic [7:0]                  start_green,
	input  logic [7:0]                  start_blue,
	input  logic [7:0]                  end_red,
	input  logic [7:0]                  end_green,
	input  logic [7:0]                  end_blue,
	input  logic [hhg_pkg::COUNT_W-1:0] inner_count,
	input  logic                        long_way,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_red,
	output logic [7:0]                  out_green,
	output logic [7:0]                  out_blue,
	output logic [hhg_pkg::COUNT_W-1:0] position,
	output logic                        final_colour
);

	hhg_pkg::cmd_t cmd;
	hhg_pkg::sts_t sts;

	hhg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	hhg_datapath #(
		.MAX_INNER (MAX_INNER)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.start_red    (start_red),
		.start_green  (start_green),
		.start_blue   (start_blue),
		.end_red      (end_red),
		.end_green    (end_green),
		.end_blue     (end_blue),
		.inner_count  (inner_count),
		.long_way     (long_way),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.position     (position),
		.final_colour (final_colour)
	);

endmodule
